[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define VN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vn check failed");

// antecedent holds in this cycle, consequent in the next one
`define VN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vn check failed");

`endif

[rtl/vn_pkg.sv]
// shared types and constants of the vector normalisation pipeline
`timescale 1ns / 1ps
`default_nettype none

package vn_pkg;

    // result bits of the search: values 0 .. 16384 need 15 bits
    localparam int Q_BITS     = 15;
    // width of one normalised output component, q2.14
    localparam int OUT_W      = 16;
    // a^2 is scaled by 2^30 so the search compares against (2m-1)^2 * s
    localparam int FRAC_SHIFT = 30;

    // sign and zero information that travels beside the search
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } vn_side_t;

endpackage

`default_nettype wire

[rtl/vn_step.sv]
// one bit of the rounded-quotient search for one component
`timescale 1ns / 1ps
`default_nettype none

module vn_step #(
    parameter int SW       = 32,
    parameter int AW       = 62,
    parameter int STEP_BIT = 14
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [SW-1:0]                     s_in,
    input  wire logic [AW-1:0]                     a_in,
    input  wire logic [vn_pkg::Q_BITS-1:0]         m_in,
    input  wire logic [SW+vn_pkg::Q_BITS-1:0]      ms_in,
    input  wire logic [SW+2*vn_pkg::Q_BITS-1:0]    m2s_in,
    output logic      [SW-1:0]                     s_reg,
    output logic      [AW-1:0]                     a_reg,
    output logic      [vn_pkg::Q_BITS-1:0]         m_reg,
    output logic      [SW+vn_pkg::Q_BITS-1:0]      ms_reg,
    output logic      [SW+2*vn_pkg::Q_BITS-1:0]    m2s_reg
);

    localparam int QB  = vn_pkg::Q_BITS;
    localparam int MSW = SW + QB;
    localparam int M2W = SW + 2 * QB;
    localparam int CW  = SW + 2 * QB + 2;

    logic [CW-1:0]  s_ext;
    logic [CW-1:0]  ms_c;
    logic [CW-1:0]  m2s_c;
    logic [CW-1:0]  f_c;
    logic           take;
    logic [QB-1:0]  m_next;
    logic [MSW-1:0] ms_next;
    logic [M2W-1:0] m2s_next;

    // trial m + 2^k: (m+t)^2 s = m^2 s + 2t*ms + t^2 s, (m+t) s = ms + t s
    always_comb
    begin
        s_ext    = CW'(s_in);
        ms_c     = CW'(ms_in) + (s_ext << STEP_BIT);
        m2s_c    = CW'(m2s_in) + (CW'(ms_in) << (STEP_BIT + 1)) + (s_ext << (2 * STEP_BIT));
        // (2m-1)^2 s = 4 (m^2 s - m s) + s
        f_c      = ((m2s_c - ms_c) << 2) + s_ext;
        take     = (f_c <= CW'(a_in));
        m_next   = take ? (m_in | (QB'(1) << STEP_BIT)) : m_in;
        ms_next  = take ? MSW'(ms_c) : ms_in;
        m2s_next = take ? M2W'(m2s_c) : m2s_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= s_in;
            a_reg   <= a_in;
            m_reg   <= m_next;
            ms_reg  <= ms_next;
            m2s_reg <= m2s_next;
        end
    end

endmodule

`default_nettype wire

[rtl/vector3_normalize.sv]
// top level of the three-component vector normalisation pipeline
//
//   channel | signals                          | direction
//   input   | in_valid, in_stall, x/y/z_in     | vector in, stall back
//   output  | out_valid, out_stall, x/y/z_out, | unit vector out, stall in
//           | zero_length                      |
//
// one item per cycle while the output is not stalled; stages: square, sum, 15 search bits, output
// the 15 bit-serial search stages, one result bit each, set the depth
// reset clears the valid bits only; payload registers are not reset
// a stall at the output freezes every stage at once, nothing is lost
`timescale 1ns / 1ps
`default_nettype none

module vector3_normalize #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [COMPONENT_WIDTH-1:0] x_in,
    input  wire logic signed [COMPONENT_WIDTH-1:0] y_in,
    input  wire logic signed [COMPONENT_WIDTH-1:0] z_in,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [vn_pkg::OUT_W-1:0]        x_out,
    output logic signed [vn_pkg::OUT_W-1:0]        y_out,
    output logic signed [vn_pkg::OUT_W-1:0]        z_out,
    output logic                                   zero_length
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int SW  = 2 * W;                       // sum of squares fits
    localparam int AW  = 2 * W + vn_pkg::FRAC_SHIFT;  // scaled a^2
    localparam int QB  = vn_pkg::Q_BITS;
    localparam int NS  = QB;                          // one stage per result bit
    localparam int OW  = vn_pkg::OUT_W;

    // whole pipe moves together unless a finished item is held at the output
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 1: magnitudes and squares
    logic [W-1:0]  cmp_in [0:2];
    logic [W-1:0]  mag_c  [0:2];
    logic [2:0]    neg_c;
    logic [SW-1:0] sq_p1_reg [0:2];
    logic [2:0]    neg_p1_reg;
    logic          vld_p1_reg;

    assign cmp_in[0] = x_in;
    assign cmp_in[1] = y_in;
    assign cmp_in[2] = z_in;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            neg_c[c] = cmp_in[c][W-1];
            // most negative value maps to 2^(w-1), which an unsigned word holds
            mag_c[c] = neg_c[c] ? (~cmp_in[c] + 1'b1) : cmp_in[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_p1_reg[c] <= SW'(mag_c[c]) * SW'(mag_c[c]);
            end
            neg_p1_reg <= neg_c;
        end
    end

    // stage 2: squared length, scaled targets, zero detection
    logic [SW-1:0]    s_next;
    logic [SW-1:0]    s_p2_reg;
    logic [AW-1:0]    a_p2_reg [0:2];
    vn_pkg::vn_side_t side_p2_reg;
    logic             vld_p2_reg;

    // three squares of at most 2^(2w-2) stay below 2^(2w)
    assign s_next = sq_p1_reg[0] + sq_p1_reg[1] + sq_p1_reg[2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_p2_reg <= s_next;
            for (int c = 0; c < 3; c++)
            begin
                a_p2_reg[c] <= AW'(sq_p1_reg[c]) << vn_pkg::FRAC_SHIFT;
            end
            side_p2_reg.neg  <= neg_p1_reg;
            side_p2_reg.zero <= (s_next == '0);
        end
    end

    // search stages: largest m with (2m-1)^2 s <= a^2 2^30 is round(a 2^14 / sqrt s)
    logic [SW-1:0]       s_w   [0:2][0:NS];
    logic [AW-1:0]       a_w   [0:2][0:NS];
    logic [QB-1:0]       m_w   [0:2][0:NS];
    logic [SW+QB-1:0]    ms_w  [0:2][0:NS];
    logic [SW+2*QB-1:0]  m2s_w [0:2][0:NS];
    vn_pkg::vn_side_t    side_st_reg [0:NS-1];
    logic [NS-1:0]       vld_st_reg;

    genvar gc, gj;
    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_comp
            assign s_w[gc][0]   = s_p2_reg;
            assign a_w[gc][0]   = a_p2_reg[gc];
            assign m_w[gc][0]   = '0;
            assign ms_w[gc][0]  = '0;
            assign m2s_w[gc][0] = '0;
            for (gj = 0; gj < NS; gj++)
            begin : g_bit
                vn_step #(
                    .SW       (SW),
                    .AW       (AW),
                    .STEP_BIT (NS - 1 - gj)
                ) u_step (
                    .clk     (clk),
                    .en      (adv),
                    .s_in    (s_w[gc][gj]),
                    .a_in    (a_w[gc][gj]),
                    .m_in    (m_w[gc][gj]),
                    .ms_in   (ms_w[gc][gj]),
                    .m2s_in  (m2s_w[gc][gj]),
                    .s_reg   (s_w[gc][gj+1]),
                    .a_reg   (a_w[gc][gj+1]),
                    .m_reg   (m_w[gc][gj+1]),
                    .ms_reg  (ms_w[gc][gj+1]),
                    .m2s_reg (m2s_w[gc][gj+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_st_reg[0] <= side_p2_reg;
            for (int j = 1; j < NS; j++)
            begin
                side_st_reg[j] <= side_st_reg[j-1];
            end
        end
    end

    // output stage: restore sign, force zeros for a zero vector
    logic [OW-1:0] res_c [0:2];
    logic [OW-1:0] x_out_reg;
    logic [OW-1:0] y_out_reg;
    logic [OW-1:0] z_out_reg;
    logic          zero_reg;
    logic          vld_out_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (side_st_reg[NS-1].zero)
            begin
                res_c[c] = '0;
            end
            else if (side_st_reg[NS-1].neg[c])
            begin
                res_c[c] = OW'(0) - OW'(m_w[c][NS]);
            end
            else
            begin
                res_c[c] = OW'(m_w[c][NS]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_out_reg <= res_c[0];
            y_out_reg <= res_c[1];
            z_out_reg <= res_c[2];
            zero_reg  <= side_st_reg[NS-1].zero;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p1_reg  <= 1'b0;
            vld_p2_reg  <= 1'b0;
            vld_st_reg  <= '0;
            vld_out_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_p1_reg  <= in_valid;
            vld_p2_reg  <= vld_p1_reg;
            vld_st_reg  <= {vld_st_reg[NS-2:0], vld_p2_reg};
            vld_out_reg <= vld_st_reg[NS-1];
        end
    end

    assign out_valid   = vld_out_reg;
    assign x_out       = x_out_reg;
    assign y_out       = y_out_reg;
    assign z_out       = z_out_reg;
    assign zero_length = zero_reg;

endmodule

`default_nettype wire

[rtl/vn_check.sv]
// port-level checker for the vector normalisation block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vn_check (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_stall,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic signed [vn_pkg::OUT_W-1:0]  x_out,
    input wire logic signed [vn_pkg::OUT_W-1:0]  y_out,
    input wire logic signed [vn_pkg::OUT_W-1:0]  z_out,
    input wire logic                             zero_length
);

    logic out_in_range;

    // every component within plus or minus one in q2.14
    assign out_in_range = (x_out <= 16384) && (x_out >= -16384)
                       && (y_out <= 16384) && (y_out >= -16384)
                       && (z_out <= 16384) && (z_out >= -16384);

    // a held result keeps valid
    `VN_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
    // input side only stalls behind a stalled result
    `VN_ASSERT_SAME(a_stall_src, in_stall, out_valid && out_stall)
    // a zero vector gives zero components
    `VN_ASSERT_SAME(a_zero, out_valid && zero_length, x_out == 0 && y_out == 0 && z_out == 0)
    // unit vector components stay within plus or minus one
    `VN_ASSERT_SAME(a_range, out_valid, out_in_range)

endmodule

bind vector3_normalize vn_check u_vn_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_out       (x_out),
    .y_out       (y_out),
    .z_out       (z_out),
    .zero_length (zero_length)
);

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench of the vector normalisation pipeline
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zero;
    } unit_t;

    localparam int RANDOM_ITEMS = 1680;
    localparam int HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic signed [15:0] z_in;
    logic out_valid;
    logic out_stall;
    logic signed [vn_pkg::OUT_W-1:0] x_out;
    logic signed [vn_pkg::OUT_W-1:0] y_out;
    logic signed [vn_pkg::OUT_W-1:0] z_out;
    logic zero_length;

    vec_t  vectors_to_send[$];
    unit_t units_awaited[$];
    int    n_loaded;
    int    n_sent;
    int    n_checked;
    int    n_zero;
    int    n_errors;
    bit    loading_done;
    int    hold_left;
    bit    hold_done;

    vector3_normalize #(.COMPONENT_WIDTH(16)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .x_in(x_in),
        .y_in(y_in),
        .z_in(z_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .x_out(x_out),
        .y_out(y_out),
        .z_out(z_out),
        .zero_length(zero_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // round(mag * 16384 / sqrt(sum)), ties away from zero, by bisection on
    // mag^2 * 2^30 >= (2m-1)^2 * sum so no rounding creeps in
    function automatic logic [15:0] unit_magnitude(logic [16:0] mag, logic [35:0] sum);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        lhs = (128'(mag) * 128'(mag)) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            rhs = 128'(2 * mid - 1) * 128'(2 * mid - 1) * 128'(sum);
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[15:0];
    endfunction

    function automatic unit_t normalise(vec_t v);
        logic signed [15:0] comp[3];
        logic [16:0] mag[3];
        logic [35:0] sum;
        logic [15:0] r[3];
        unit_t u;
        comp[0] = v.x;
        comp[1] = v.y;
        comp[2] = v.z;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = comp[i][15] ? 17'(-$signed(17'(comp[i]))) : 17'(comp[i]);
            sum += 36'(mag[i]) * 36'(mag[i]);
        end
        if (sum == 0)
            return '{x: '0, y: '0, z: '0, zero: 1'b1};
        for (int i = 0; i < 3; i++)
        begin
            r[i] = unit_magnitude(mag[i], sum);
            if (comp[i][15])
                r[i] = -r[i];
        end
        u.x = r[0];
        u.y = r[1];
        u.z = r[2];
        u.zero = 1'b0;
        return u;
    endfunction

    function automatic logic signed [15:0] small_comp();
        return 16'($signed(8'($urandom)) >>> $urandom_range(0, 7));
    endfunction

    // stimulus: directed corners first, then mostly full-range vectors
    // with some small, one-axis-heavy and zero vectors mixed in
    initial
    begin : load_vectors
        vec_t v;
        int kind;
        vectors_to_send.push_back('{0, 0, 0});
        vectors_to_send.push_back('{32767, 0, 0});
        vectors_to_send.push_back('{0, -32768, 0});
        vectors_to_send.push_back('{0, 0, -32767});
        vectors_to_send.push_back('{-32768, -32768, -32768});
        vectors_to_send.push_back('{32767, 32767, 32767});
        vectors_to_send.push_back('{-32768, 32767, 0});
        vectors_to_send.push_back('{1, 0, 0});
        vectors_to_send.push_back('{0, -1, 0});
        vectors_to_send.push_back('{1, 1, 1});
        vectors_to_send.push_back('{-1, 2, -2});
        vectors_to_send.push_back('{3, 4, 0});
        vectors_to_send.push_back('{0, -4, 3});
        vectors_to_send.push_back('{2, 3, 6});
        vectors_to_send.push_back('{1, 32767, -1});
        vectors_to_send.push_back('{-32768, 1, 1});
        vectors_to_send.push_back('{16384, 16384, 0});
        vectors_to_send.push_back('{-21846, 21845, -21845});
        vectors_to_send.push_back('{0, 0, 0});
        vectors_to_send.push_back('{-1, -1, -1});
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 11)
                v = '{16'($urandom), 16'($urandom), 16'($urandom)};
            else if (kind < 15)
                v = '{small_comp(), small_comp(), small_comp()};
            else if (kind < 18)
            begin
                v = '{small_comp(), small_comp(), small_comp()};
                case ($urandom_range(0, 2))
                    0: v.x = 16'($urandom);
                    1: v.y = 16'($urandom);
                    default: v.z = 16'($urandom);
                endcase
            end
            else if (kind == 18)
                v = '{0, 0, 0};
            else
                v = '{$urandom_range(0, 1) ? -32768 : 32767, 0, small_comp()};
            vectors_to_send.push_back(v);
        end
        n_loaded = vectors_to_send.size();
        loading_done = 1'b1;
    end

    // driver: gaps drawn per item, with quiet stretches of back-to-back items
    int  tx_gap;
    bit  tx_quiet;
    always @(posedge clk or negedge rst_n)
    begin
        vec_t v;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_in     <= '0;
            y_in     <= '0;
            z_in     <= '0;
            tx_gap   = 0;
            tx_quiet = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                units_awaited.push_back(normalise('{x_in, y_in, z_in}));
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (vectors_to_send.size() > 0)
                begin
                    v = vectors_to_send.pop_front();
                    x_in     <= v.x;
                    y_in     <= v.y;
                    z_in     <= v.z;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 99) == 0)
                        tx_quiet = !tx_quiet;
                    tx_gap = tx_quiet ? 0 : $urandom_range(0, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long output hold-off once, well into the run, so the pipe backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_sent >= 300)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: compare each result with the oldest prediction
    int  rx_wait;
    bit  rx_quiet;
    always @(posedge clk or negedge rst_n)
    begin
        unit_t exp_u;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait  = 0;
            rx_quiet = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (units_awaited.size() == 0)
                begin
                    $error("result with nothing awaited: x %0d y %0d z %0d zero %0b",
                           x_out, y_out, z_out, zero_length);
                    n_errors++;
                end
                else
                begin
                    exp_u = units_awaited.pop_front();
                    n_checked++;
                    if (exp_u.zero)
                        n_zero++;
                    if (x_out !== exp_u.x)
                    begin
                        $error("x_out expected %0d actual %0d", exp_u.x, x_out);
                        n_errors++;
                    end
                    if (y_out !== exp_u.y)
                    begin
                        $error("y_out expected %0d actual %0d", exp_u.y, y_out);
                        n_errors++;
                    end
                    if (z_out !== exp_u.z)
                    begin
                        $error("z_out expected %0d actual %0d", exp_u.z, z_out);
                        n_errors++;
                    end
                    if (zero_length !== exp_u.zero)
                    begin
                        $error("zero_length expected %0b actual %0b", exp_u.zero,
                               zero_length);
                        n_errors++;
                    end
                end
                if ($urandom_range(0, 99) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
            end
            out_stall <= (hold_left > 1) || (rx_wait > 0);
            if (rx_wait > 0)
                rx_wait--;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (loading_done && n_sent == n_loaded && units_awaited.size() == 0);
        repeat (40) @(posedge clk);
        if (units_awaited.size() != 0)
        begin
            $error("%0d results never arrived", units_awaited.size());
            n_errors++;
        end
        $display("checked %0d vectors (%0d zero), one long output hold-off included",
                 n_checked, n_zero);
        if (n_errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still awaited", units_awaited.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule
